FILE: rtl/dspf_pkg.sv
`default_nettype none
package dspf_pkg;

  localparam int SQ_W = 66;
  localparam int ROOT_W = 34;
  localparam int DVD_W = 64;
  localparam int DVS_W = 34;
  localparam int QUO_W = 31;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_REST_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 2'd2;

  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic [30:0]        mass_a;
    logic [30:0]        mass_b;
    logic               kinematic_a;
    logic               kinematic_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] force_a_x;
    logic signed [31:0] force_a_y;
    logic signed [31:0] force_b_x;
    logic signed [31:0] force_b_y;
    logic               coincident;
  } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/dspf_in_if.sv
`default_nettype none
interface dspf_in_if import dspf_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/dspf_out_if.sv
`default_nettype none
interface dspf_out_if import dspf_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/dspf_cfg_if.sv
`default_nettype none
interface dspf_cfg_if import dspf_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/dspf_sqrt.sv
`default_nettype none
module dspf_sqrt import dspf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [SQ_W-1:0]   din,
  output logic      [ROOT_W-1:0] root
);

  localparam int RW = 2 * ROOT_W + 1;

  logic [RW-1:0]     rem_r  [ROOT_W-1];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam int B = ROOT_W - 1 - i;
    logic [RW-1:0]     rem_in;
    logic [RW-1:0]     trial;
    logic [ROOT_W-1:0] root_in;
    logic              take;

    if (i == 0) begin : g_first
      assign rem_in  = RW'(din);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
    end

    assign trial = (RW'(root_in) << (B + 1)) + (RW'(1) << (2 * B));
    assign take  = (trial <= rem_in);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[i] <= take ? (root_in | (ROOT_W'(1) << B)) : root_in;
      end
    end

    if (i < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= take ? (rem_in - trial) : rem_in;
        end
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule
`default_nettype wire

FILE: rtl/dspf_div.sv
`default_nettype none
module dspf_div import dspf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic      [QUO_W-1:0] quot
);

  localparam int RW = DVS_W + QUO_W;

  logic [RW-1:0]    rem_r [QUO_W-1];
  logic [DVS_W-1:0] d_r   [QUO_W-1];
  logic [QUO_W-1:0] q_r   [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    localparam int J = QUO_W - 1 - i;
    logic [RW-1:0]    rem_in;
    logic [RW-1:0]    trial;
    logic [DVS_W-1:0] d_in;
    logic [QUO_W-1:0] q_in;
    logic             take;

    if (i == 0) begin : g_first
      assign rem_in = RW'(dividend);
      assign d_in   = divisor;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign d_in   = d_r[i-1];
      assign q_in   = q_r[i-1];
    end

    assign trial = RW'(d_in) << J;
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i] <= take ? (q_in | (QUO_W'(1) << J)) : q_in;
      end
    end

    if (i < QUO_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= take ? (rem_in - trial) : rem_in;
          d_r[i]   <= d_in;
        end
      end
    end
  end

  assign quot = q_r[QUO_W-1];

endmodule
`default_nettype wire

FILE: rtl/damped_spring_pair_force.sv
`default_nettype none
// Damped spring force between two 2D bodies in Q16.16. One body pair is taken per clock
// unless the pipeline stalls; the pipeline holds up to 77 pairs plus one finished result
// in the output register, and it stalls only when that register is full, not taken, and
// the last stage holds another result. The pipeline depth is set by the 34-stage square
// root of the separation followed by the 31-stage divider that forms the unit normal;
// critical damping runs a mass divider and a second square root in parallel.
// Configuration writes take effect at once and belong between batches, when no pair is
// in flight.
module damped_spring_pair_force import dspf_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dspf_cfg_if.sink    cfg_ch,
  dspf_in_if.sink     in_ch,
  dspf_out_if.source  out_ch
);

  localparam int DEPTH    = 77;
  localparam int ST_COINC = 3;
  localparam int ST_LEN   = 38;
  localparam int ST_C     = 68;

  typedef struct packed {
    logic signed [32:0]  dx;
    logic signed [32:0]  dy;
    logic signed [32:0]  vrx;
    logic signed [32:0]  vry;
    logic                kin_a;
    logic                kin_b;
    logic                coinc;
    logic [ROOT_W-1:0]   len;
    logic signed [33:0]  c;
  } ctx_t;

  function automatic logic [32:0] mag33(logic signed [32:0] a);
    return a[32] ? 33'(-a) : 33'(a);
  endfunction

  function automatic logic signed [31:0] sat_force(logic neg, logic [71:0] mag);
    logic big;
    big = |mag[71:31];
    if (big) begin
      return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return neg ? -$signed(mag[31:0]) : $signed(mag[31:0]);
  endfunction

  // configuration registers
  logic [30:0]        rest_length_r;
  logic [30:0]        stiffness_r;
  logic signed [31:0] damping_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_length_r <= 31'd65536;
      stiffness_r   <= 31'd65536;
      damping_r     <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_REST_LENGTH: rest_length_r <= cfg_ch.data[30:0];
        REG_STIFFNESS:   stiffness_r   <= cfg_ch.data[30:0];
        REG_DAMPING:     damping_r     <= $signed(cfg_ch.data);
        default: ;
      endcase
    end
  end

  // pipeline control
  logic             en;
  logic [DEPTH:1]   v_r;
  ctx_t             ctx_r [1:DEPTH];
  ctx_t             ctx_in;
  logic             out_valid_r;
  out_item_t        out_data_r;

  assign en          = !v_r[DEPTH] || !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DEPTH-1:1], in_ch.valid};
    end
  end

  // stage 1: differences and mass terms
  logic [61:0] prod_m_r;
  logic [31:0] msum_r;

  always_comb begin
    ctx_in       = '0;
    ctx_in.dx    = 33'(in_ch.data.pos_b_x) - 33'(in_ch.data.pos_a_x);
    ctx_in.dy    = 33'(in_ch.data.pos_b_y) - 33'(in_ch.data.pos_a_y);
    ctx_in.vrx   = 33'(in_ch.data.vel_b_x) - 33'(in_ch.data.vel_a_x);
    ctx_in.vry   = 33'(in_ch.data.vel_b_y) - 33'(in_ch.data.vel_a_y);
    ctx_in.kin_a = in_ch.data.kinematic_a;
    ctx_in.kin_b = in_ch.data.kinematic_b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[1] <= ctx_in;
      prod_m_r <= 62'(in_ch.data.mass_a) * 62'(in_ch.data.mass_b);
      msum_r   <= 32'(in_ch.data.mass_a) + 32'(in_ch.data.mass_b);
    end
  end

  // stages 2 and 3: squared length
  logic [SQ_W-1:0] dx2_r;
  logic [SQ_W-1:0] dy2_r;
  logic [SQ_W-1:0] sq_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dx2_r <= SQ_W'(mag33(ctx_r[1].dx)) * SQ_W'(mag33(ctx_r[1].dx));
      dy2_r <= SQ_W'(mag33(ctx_r[1].dy)) * SQ_W'(mag33(ctx_r[1].dy));
      sq_r  <= dx2_r + dy2_r;
    end
  end

  // length, normal and reduced mass units
  logic [ROOT_W-1:0] len_q;
  logic [ROOT_W-1:0] root_c;
  logic [QUO_W-1:0]  m_q;
  logic [QUO_W-1:0]  nx_q;
  logic [QUO_W-1:0]  ny_q;
  logic [61:0]       km_r;

  dspf_sqrt u_sqrt_len (
    .clk  (clk),
    .en   (en),
    .din  (sq_r),
    .root (len_q)
  );

  dspf_div u_div_mass (
    .clk      (clk),
    .en       (en),
    .dividend (DVD_W'(prod_m_r)),
    .divisor  ((msum_r == '0) ? DVS_W'(1) : DVS_W'(msum_r)),
    .quot     (m_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      km_r <= 62'(stiffness_r) * 62'(m_q);
    end
  end

  dspf_sqrt u_sqrt_crit (
    .clk  (clk),
    .en   (en),
    .din  (SQ_W'(km_r)),
    .root (root_c)
  );

  dspf_div u_div_nx (
    .clk      (clk),
    .en       (en),
    .dividend (DVD_W'({mag33(ctx_r[ST_LEN-1].dx), 16'b0})),
    .divisor  (DVS_W'(len_q)),
    .quot     (nx_q)
  );

  dspf_div u_div_ny (
    .clk      (clk),
    .en       (en),
    .dividend (DVD_W'({mag33(ctx_r[ST_LEN-1].dy), 16'b0})),
    .divisor  (DVS_W'(len_q)),
    .quot     (ny_q)
  );

  // context line
  for (genvar k = 2; k <= DEPTH; k++) begin : g_ctx
    always_ff @(posedge clk) begin
      if (en) begin
        ctx_r[k] <= ctx_r[k-1];
        if (k == ST_COINC) begin
          ctx_r[k].coinc <= (ctx_r[k-1].dx == '0) && (ctx_r[k-1].dy == '0);
        end
        if (k == ST_LEN) begin
          ctx_r[k].len <= len_q;
        end
        if (k == ST_C) begin
          ctx_r[k].c <= damping_r[31] ? $signed({root_c[32:0], 1'b0}) : 34'(damping_r);
        end
      end
    end
  end

  // force arithmetic
  logic signed [17:0] nx_r, ny_r, nx_nxt, ny_nxt;
  logic signed [50:0] pvx_r, pvy_r;
  logic signed [51:0] psum_r;
  logic [64:0]        sprod_r, sprod_nxt;
  logic               spr_neg_r;
  logic signed [34:0] diff;
  logic [33:0]        absdiff;
  logic signed [36:0] vdot_r, vdot_nxt;
  logic signed [51:0] adj;
  logic signed [50:0] spring72_r, spring73_r, spring74_r, spring_nxt;
  logic [35:0]        vmag;
  logic [68:0]        dprod_r;
  logic               dneg_r;
  logic signed [54:0] damp_r, damp_nxt;
  logic signed [54:0] force_r;
  logic [53:0]        fmag;
  logic [32:0]        adx, ady;
  logic [59:0]        plo_x_r, phi_x_r, plo_y_r, phi_y_r;
  logic               fneg76_r, fneg77_r;
  logic [87:0]        px_r, py_r;

  always_comb begin
    nx_nxt = ctx_r[ST_C].dx[32] ? -$signed({1'b0, nx_q[16:0]}) : $signed({1'b0, nx_q[16:0]});
    ny_nxt = ctx_r[ST_C].dy[32] ? -$signed({1'b0, ny_q[16:0]}) : $signed({1'b0, ny_q[16:0]});
    diff = $signed({1'b0, ctx_r[70].len}) - $signed({4'b0, rest_length_r});
    absdiff = diff[34] ? 34'(-diff) : diff[33:0];
    sprod_nxt = 65'(stiffness_r) * 65'(absdiff);
    adj = psum_r + (psum_r[51] ? 52'sd65535 : 52'sd0);
    vdot_nxt = 37'(adj >>> 16);
    spring_nxt = spr_neg_r ? -$signed({2'b0, sprod_r[64:16]}) : $signed({2'b0, sprod_r[64:16]});
    vmag = vdot_r[36] ? 36'(-vdot_r) : vdot_r[35:0];
    damp_nxt = dneg_r ? -$signed({2'b0, dprod_r[68:16]}) : $signed({2'b0, dprod_r[68:16]});
    fmag = force_r[54] ? 54'(-force_r) : force_r[53:0];
    adx = mag33(ctx_r[75].dx);
    ady = mag33(ctx_r[75].dy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r       <= nx_nxt;
      ny_r       <= ny_nxt;
      pvx_r      <= 51'(ctx_r[69].vrx) * 51'(nx_r);
      pvy_r      <= 51'(ctx_r[69].vry) * 51'(ny_r);
      psum_r     <= 52'(pvx_r) + 52'(pvy_r);
      sprod_r    <= sprod_nxt;
      spr_neg_r  <= diff[34];
      vdot_r     <= vdot_nxt;
      spring72_r <= spring_nxt;
      dprod_r    <= 69'(ctx_r[72].c[32:0]) * 69'(vmag);
      dneg_r     <= vdot_r[36];
      spring73_r <= spring72_r;
      damp_r     <= damp_nxt;
      spring74_r <= spring73_r;
      force_r    <= -(55'(spring74_r) + damp_r);
      plo_x_r    <= 60'(adx) * 60'(fmag[26:0]);
      phi_x_r    <= 60'(adx) * 60'(fmag[53:27]);
      plo_y_r    <= 60'(ady) * 60'(fmag[26:0]);
      phi_y_r    <= 60'(ady) * 60'(fmag[53:27]);
      fneg76_r   <= force_r[54];
      px_r       <= 88'(plo_x_r) + (88'(phi_x_r) << 27);
      py_r       <= 88'(plo_y_r) + (88'(phi_y_r) << 27);
      fneg77_r   <= fneg76_r;
    end
  end

  // split between the bodies and saturate
  logic        whole;
  logic [71:0] mag_x, mag_y;
  logic        s_x, s_y;
  out_item_t   out_nxt;

  always_comb begin
    whole   = ctx_r[DEPTH].kin_a || ctx_r[DEPTH].kin_b;
    mag_x   = whole ? px_r[87:16] : {1'b0, px_r[87:17]};
    mag_y   = whole ? py_r[87:16] : {1'b0, py_r[87:17]};
    s_x     = ctx_r[DEPTH].dx[32] ^ fneg77_r;
    s_y     = ctx_r[DEPTH].dy[32] ^ fneg77_r;
    out_nxt = '0;
    out_nxt.coincident = ctx_r[DEPTH].coinc;
    if (!ctx_r[DEPTH].coinc) begin
      if (ctx_r[DEPTH].kin_a) begin
        out_nxt.force_b_x = sat_force(s_x, mag_x);
        out_nxt.force_b_y = sat_force(s_y, mag_y);
      end else if (ctx_r[DEPTH].kin_b) begin
        out_nxt.force_a_x = sat_force(!s_x, mag_x);
        out_nxt.force_a_y = sat_force(!s_y, mag_y);
      end else begin
        out_nxt.force_b_x = sat_force(s_x, mag_x);
        out_nxt.force_b_y = sat_force(s_y, mag_y);
        out_nxt.force_a_x = sat_force(!s_x, mag_x);
        out_nxt.force_a_y = sat_force(!s_y, mag_y);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && v_r[DEPTH]) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v_r[DEPTH]) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[DEPTH] && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while pipeline is stalled");

  a_coincident_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.coincident) |->
      (out_data_r.force_a_x == '0 && out_data_r.force_a_y == '0 &&
       out_data_r.force_b_x == '0 && out_data_r.force_b_y == '0))
    else $error("coincident result carries a force");

  a_kinematic_a_free: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v_r[DEPTH] && ctx_r[DEPTH].kin_a) |=>
      (out_data_r.force_a_x == '0 && out_data_r.force_a_y == '0))
    else $error("force applied to kinematic body a");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v_r[DEPTH]) |=> out_valid_r)
    else $error("finished result lost at output register");

endmodule
`default_nettype wire

FILE: dv/damped_spring_pair_force_tb.sv
`timescale 1ns / 100ps
module damped_spring_pair_force_tb;
  import dspf_pkg::*;

  class force_scoreboard;
    out_item_t pending[$];
    int errors;
    logic [30:0] rest_len;
    logic [30:0] spring_k;
    logic signed [31:0] damp_c;

    function new();
      errors = 0;
      rest_len = 31'd65536;
      spring_k = 31'd65536;
      damp_c = '0;
    endfunction

    function logic [65:0] root_floor(logic [131:0] v);
      logic [65:0] r;
      logic [65:0] c;
      r = '0;
      for (int b = 65; b >= 0; b--) begin
        c = r | (66'd1 << b);
        if ({66'd0, c} * {66'd0, c} <= v) r = c;
      end
      return r;
    endfunction

    // trunc(a*b / 2^sh) toward zero, clamped to 64-bit range
    function logic signed [127:0] scale_trunc(logic signed [127:0] a,
                                              logic signed [127:0] b, int sh);
      logic [127:0] p;
      logic signed [127:0] m;
      p = (a < 0 ? -a : a) * (b < 0 ? -b : b);
      p = p >> sh;
      m = (p > 128'h7FFFFFFFFFFFFFFF) ? 128'sh7FFFFFFFFFFFFFFF : $signed(p);
      return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function logic signed [31:0] clamp32(logic signed [127:0] v);
      if (v > 128'sh7FFFFFFF) return 32'sh7FFFFFFF;
      if (v < -128'sh80000000) return 32'sh80000000;
      return v[31:0];
    endfunction

    function void note_pair(in_item_t it);
      logic signed [127:0] dx, dy, vrx, vry, len, nx, ny, vdot, c, frc, fx, fy;
      logic [127:0] ma, mb, msum, m;
      out_item_t r;
      dx = 128'(it.pos_b_x) - 128'(it.pos_a_x);
      dy = 128'(it.pos_b_y) - 128'(it.pos_a_y);
      vrx = 128'(it.vel_b_x) - 128'(it.vel_a_x);
      vry = 128'(it.vel_b_y) - 128'(it.vel_a_y);
      ma = 128'(it.mass_a);
      mb = 128'(it.mass_b);
      r = '0;
      if (dx == 0 && dy == 0) begin
        r.coincident = 1'b1;
        pending.push_back(r);
        return;
      end
      len = 128'(root_floor(132'(dx * dx + dy * dy)));
      nx = (dx * 65536) / len;
      ny = (dy * 65536) / len;
      vdot = (vrx * nx + vry * ny) / 65536;
      if (damp_c >= 0) begin
        c = 128'(damp_c);
      end else begin
        msum = ma + mb;
        m = (msum != 0) ? (ma * mb) / msum : '0;
        c = 128'({root_floor(132'(m * 128'(spring_k))), 1'b0});
      end
      frc = -(scale_trunc(128'(spring_k), len - 128'(rest_len), 16)
              + scale_trunc(c, vdot, 16));
      if (it.kinematic_a) begin
        r.force_b_x = clamp32(scale_trunc(dx, frc, 16));
        r.force_b_y = clamp32(scale_trunc(dy, frc, 16));
      end else if (it.kinematic_b) begin
        r.force_a_x = clamp32(-scale_trunc(dx, frc, 16));
        r.force_a_y = clamp32(-scale_trunc(dy, frc, 16));
      end else begin
        fx = scale_trunc(dx, frc, 17);
        fy = scale_trunc(dy, frc, 17);
        r.force_b_x = clamp32(fx);
        r.force_b_y = clamp32(fy);
        r.force_a_x = clamp32(-fx);
        r.force_a_y = clamp32(-fy);
      end
      pending.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      errors++;
    endtask

    task check_forces(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected transaction", '0, '0);
        return;
      end
      want = pending.pop_front();
      if (got.force_a_x !== want.force_a_x)
        report_mismatch("force_a_x", got.force_a_x, want.force_a_x);
      if (got.force_a_y !== want.force_a_y)
        report_mismatch("force_a_y", got.force_a_y, want.force_a_y);
      if (got.force_b_x !== want.force_b_x)
        report_mismatch("force_b_x", got.force_b_x, want.force_b_x);
      if (got.force_b_y !== want.force_b_y)
        report_mismatch("force_b_y", got.force_b_y, want.force_b_y);
      if (got.coincident !== want.coincident)
        report_mismatch("coincident", 32'(got.coincident), 32'(want.coincident));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int idle_pct;

  dspf_cfg_if cfg_ch();
  dspf_in_if in_ch();
  dspf_out_if out_ch();

  damped_spring_pair_force uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_ch(cfg_ch.sink),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  force_scoreboard sb = new();

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_pair(in_ch.data);
      if (out_ch.valid && out_ch.ready) sb.check_forces(out_ch.data);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= idle_pct);
  end

  function logic signed [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
      3: return $signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000;
      default: return $urandom;
    endcase
  endfunction

  function logic [30:0] rand_mass();
    case ($urandom_range(3))
      0: return 31'd1;
      1: return 31'h7FFFFFFF;
      2: return 31'($urandom_range(1, 32'h40000));
      default: return 31'($urandom_range(1, 32'h7FFFFFFF));
    endcase
  endfunction

  task send_pair(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.data <= it;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_REST_LENGTH: sb.rest_len = val[30:0];
      REG_STIFFNESS: sb.spring_k = val[30:0];
      default: sb.damp_c = val;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (90) @(negedge clk);
  endtask

  task send_random(int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.pos_a_x = rand_word();
      it.pos_a_y = rand_word();
      it.pos_b_x = ($urandom_range(9) == 0) ? it.pos_a_x : rand_word();
      it.pos_b_y = ($urandom_range(9) == 0) ? it.pos_a_y : rand_word();
      it.vel_a_x = rand_word();
      it.vel_a_y = rand_word();
      it.vel_b_x = rand_word();
      it.vel_b_y = rand_word();
      it.mass_a = rand_mass();
      it.mass_b = rand_mass();
      it.kinematic_a = 1'($urandom_range(1));
      it.kinematic_b = 1'($urandom_range(1));
      send_pair(it);
    end
  endtask

  task directed_set();
    in_item_t it;
    it = '0;
    it.mass_a = 31'd65536;
    it.mass_b = 31'd65536;
    send_pair(it);
    it.pos_b_x = 32'sd131072;
    it.vel_b_x = 32'sd65536;
    send_pair(it);
    it.kinematic_a = 1'b1;
    send_pair(it);
    it.kinematic_b = 1'b1;
    send_pair(it);
    it.kinematic_a = 1'b0;
    send_pair(it);
    it = '1;
    it.pos_a_x = 32'sh80000000;
    it.pos_a_y = 32'sh80000000;
    it.pos_b_x = 32'sh7FFFFFFF;
    it.pos_b_y = 32'sh7FFFFFFF;
    it.vel_a_x = 32'sh80000000;
    it.vel_b_y = 32'sh80000000;
    it.kinematic_a = 1'b0;
    it.kinematic_b = 1'b0;
    send_pair(it);
    it.mass_a = 31'd1;
    it.mass_b = 31'd1;
    it.pos_b_y = 32'sh80000000;
    send_pair(it);
    it.pos_a_x = 32'sh7FFFFFFF;
    send_pair(it);
    it.kinematic_b = 1'b1;
    send_pair(it);
  endtask

  initial begin
    rst_n = 1'b0;
    idle_pct = 33;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_REST_LENGTH;
    cfg_ch.data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    directed_set();
    drain();
    write_reg(REG_DAMPING, 32'hFFFFFFFF);
    directed_set();
    send_random(200);
    drain();
    write_reg(REG_REST_LENGTH, 32'd0);
    write_reg(REG_STIFFNESS, 32'h7FFFFFFF);
    write_reg(REG_DAMPING, 32'h7FFFFFFF);
    send_random(200);
    drain();
    write_reg(REG_REST_LENGTH, 32'h7FFFFFFF);
    write_reg(REG_STIFFNESS, 32'd0);
    write_reg(REG_DAMPING, 32'h80000000);
    idle_pct = 0;
    send_random(300);
    drain();
    idle_pct = 33;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_REST_LENGTH, $urandom_range(0, 32'h7FFFFFFF) >> $urandom_range(12));
      write_reg(REG_STIFFNESS, $urandom_range(0, 32'h7FFFFFFF) >> $urandom_range(20));
      write_reg(REG_DAMPING, $urandom);
      send_random(160);
      drain();
    end
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

FILE: files.f
rtl/dspf_pkg.sv
rtl/dspf_in_if.sv
rtl/dspf_out_if.sv
rtl/dspf_cfg_if.sv
rtl/dspf_sqrt.sv
rtl/dspf_div.sv
rtl/damped_spring_pair_force.sv
dv/damped_spring_pair_force_tb.sv
